// ===== src/gdad_pkg.sv =====
`default_nettype none

package gdad_pkg;

  // Fixed field widths.
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int COUNT_BITS = 22;
  localparam int DIFF_BITS  = 22;
  localparam int DOY_BITS   = 9;
  localparam int CYC_BITS   = 9;

  // Calendar constants.
  localparam int YEAR_CYCLE = 400;
  localparam int ERA_DAYS   = 146097;
  localparam int YEAR_DAYS  = 365;
  localparam int MONTHS     = 12;
  localparam int MAR_SPLIT  = 10;
  localparam int DIFF_MAX   = 4194303;

  // Request codes.
  localparam logic CMD_DIFF = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_ERA,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic check;
    logic era;
    logic year;
    logic month;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic invalid;
    logic is_add;
    logic era_ge;
    logic year_ge;
    logic month_ge;
  } dp_sts_t;

  // Leap test from the low two year bits and the year modulo 400.
  function automatic logic leap_f(input logic [1:0] low, input logic [CYC_BITS-1:0] cyc);
    logic century;
    century = (cyc == CYC_BITS'(0)) || (cyc == CYC_BITS'(100)) ||
              (cyc == CYC_BITS'(200)) || (cyc == CYC_BITS'(300));
    return ((low == 2'b00) && !century) || (cyc == CYC_BITS'(0));
  endfunction

  // Length of a civil month, zero for a month code that means nothing.
  function automatic logic [DAY_BITS-1:0] civil_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Length of a month counted from March (index 0 = March, 11 = February).
  function automatic logic [DAY_BITS-1:0] mar_len(input logic [MONTH_BITS-1:0] mp,
                                                  input logic leap);
    logic [DAY_BITS-1:0] len;
    unique case (mp)
      4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
      4'd11:                  len = leap ? 5'd29 : 5'd28;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of a civil month.
  function automatic logic [DOY_BITS-1:0] doy_of(input logic [MONTH_BITS-1:0] m);
    logic [DOY_BITS-1:0] d;
    unique case (m)
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/gregorian_date_add_and_difference_unit.sv =====
// Channel   Handshake               Payload
// request   start in, busy out      in_cmd, in_month_a/b, in_day_a/b, in_year_a/b, in_day_count
// result    out_valid strobe out    out_day_difference, out_result_month/day/year, flags
//
// A request is taken when start is high and busy is low; busy stays high until
// the cycle after the result strobe, when the next request can be taken. After the
// accepting edge the unit walks one year per step from the bottom of the year range up
// to the later March-based year (that of date a for an add), at most 2^YEAR_BITS + 1
// steps, then checks the dates; an add then takes at most 28 steps of 400 years, at
// most 399 single years and at most 11 months.
// Reset is synchronous and returns the controller to idle; the strobe lasts one
// cycle and the receiver cannot stall it.
`default_nettype none

module gregorian_date_add_and_difference_unit #(
  parameter int YEAR_BITS = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_cmd,
  input  wire logic [3:0]                    in_month_a,
  input  wire logic [4:0]                    in_day_a,
  input  wire logic signed [YEAR_BITS-1:0]   in_year_a,
  input  wire logic [3:0]                    in_month_b,
  input  wire logic [4:0]                    in_day_b,
  input  wire logic signed [YEAR_BITS-1:0]   in_year_b,
  input  wire logic [21:0]                   in_day_count,
  output logic                               out_valid,
  output logic [21:0]                        out_day_difference,
  output logic [3:0]                         out_result_month,
  output logic [4:0]                         out_result_day,
  output logic signed [YEAR_BITS-1:0]        out_result_year,
  output logic                               out_date_invalid,
  output logic                               out_year_overflow
);
  import gdad_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer.
  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_sts    (dp_sts),
    .dp_cmd    (dp_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Calendar datapath.
  gdad_dp #(
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk                (clk),
    .dp_cmd             (dp_cmd),
    .dp_sts             (dp_sts),
    .in_cmd             (in_cmd),
    .in_month_a         (in_month_a),
    .in_day_a           (in_day_a),
    .in_year_a          (in_year_a),
    .in_month_b         (in_month_b),
    .in_day_b           (in_day_b),
    .in_year_b          (in_year_b),
    .in_day_count       (in_day_count),
    .out_day_difference (out_day_difference),
    .out_result_month   (out_result_month),
    .out_result_day     (out_result_day),
    .out_result_year    (out_result_year),
    .out_date_invalid   (out_date_invalid),
    .out_year_overflow  (out_year_overflow)
  );

  // An accepted request keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result appears only while a request is in flight.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a request");

  // One strobe per request: the unit is idle right after a result.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe repeated");

  // An invalid date clears every other result field.
  a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_invalid |-> (out_day_difference == '0) &&
      (out_result_month == '0) && (out_result_day == '0) && !out_year_overflow)
    else $error("invalid date result carries data");

endmodule

`default_nettype wire

// ===== src/gdad_ctrl.sv =====
`default_nettype none

module gdad_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire gdad_pkg::dp_sts_t dp_sts,
  output gdad_pkg::dp_cmd_t      dp_cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import gdad_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          dp_cmd.load = 1'b1;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        dp_cmd.walk = 1'b1;
        if (dp_sts.walk_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        dp_cmd.check = 1'b1;
        state_nxt = (dp_sts.invalid || !dp_sts.is_add) ? ST_DONE : ST_ERA;
      end
      ST_ERA: begin
        dp_cmd.era = 1'b1;
        if (!dp_sts.era_ge) begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        dp_cmd.year = 1'b1;
        if (!dp_sts.year_ge) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        dp_cmd.month = 1'b1;
        if (!dp_sts.month_ge) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/gdad_dp.sv =====
`default_nettype none

module gdad_dp #(
  parameter int YEAR_BITS = 13
) (
  input  wire logic                          clk,
  input  wire gdad_pkg::dp_cmd_t             dp_cmd,
  output gdad_pkg::dp_sts_t                  dp_sts,
  input  wire logic                          in_cmd,
  input  wire logic [3:0]                    in_month_a,
  input  wire logic [4:0]                    in_day_a,
  input  wire logic signed [YEAR_BITS-1:0]   in_year_a,
  input  wire logic [3:0]                    in_month_b,
  input  wire logic [4:0]                    in_day_b,
  input  wire logic signed [YEAR_BITS-1:0]   in_year_b,
  input  wire logic [21:0]                   in_day_count,
  output logic [21:0]                        out_day_difference,
  output logic [3:0]                         out_result_month,
  output logic [4:0]                         out_result_day,
  output logic signed [YEAR_BITS-1:0]        out_result_year,
  output logic                               out_date_invalid,
  output logic                               out_year_overflow
);
  import gdad_pkg::*;

  // Year width with room for an add that runs past the top of the range.
  localparam int YW       = YEAR_BITS + 15;
  // Day accumulator for the difference walk.
  localparam int AW       = YEAR_BITS + 10;
  localparam int MW       = (AW + 1 > DIFF_BITS + 1) ? AW + 1 : DIFF_BITS + 1;
  localparam int NW       = COUNT_BITS + 1;
  localparam int MaxYear  = 2 ** (YEAR_BITS - 1) - 1;
  localparam int BaseYear = -(2 ** (YEAR_BITS - 1)) - 1;
  localparam int BaseCyc  = ((BaseYear % YEAR_CYCLE) + YEAR_CYCLE) % YEAR_CYCLE;

  // Request registers.
  logic                    cmd_r;
  logic [MONTH_BITS-1:0]   ma_r, mb_r;
  logic [DAY_BITS-1:0]     da_r, db_r;
  logic signed [YW-1:0]    ya_r, yb_r;
  logic signed [YW-1:0]    lo_r, hi_r, target_r;
  logic [DOY_BITS-1:0]     doya_r, doy_lo_r, doy_hi_r;
  logic [COUNT_BITS-1:0]   cnt_r;

  // Walk registers.
  logic signed [YW-1:0]    y_r;
  logic [CYC_BITS-1:0]     cyc_r;
  logic [AW-1:0]           acc_r;
  logic                    leap_a_r, leap_b_r;
  logic [NW-1:0]           n_r;
  logic [MONTH_BITS-1:0]   mp_r;

  // Load-time values.
  logic signed [YW-1:0]    ya_ext, yb_ext, yya, yyb;
  logic [DOY_BITS-1:0]     doya, doyb;

  // Walk-time values.
  logic signed [YW-1:0]    y_inc;
  logic [CYC_BITS-1:0]     cyc_inc;
  logic                    leap_cur, leap_nxt;
  logic [DOY_BITS-1:0]     ylen;
  logic [DAY_BITS-1:0]     mlen;
  logic                    valid_a, valid_b, invalid;
  logic [MW-1:0]           sum_hi, lo_ext, mag;
  logic [DIFF_BITS-1:0]    diff_sat;
  logic [MONTH_BITS-1:0]   res_month;
  logic signed [YW-1:0]    res_year;

  // March-based years: January and February belong to the year before.
  always_comb begin
    ya_ext = YW'(in_year_a);
    yb_ext = YW'(in_year_b);
    yya    = ya_ext - ((in_month_a <= 4'd2) ? YW'(1) : YW'(0));
    yyb    = yb_ext - ((in_month_b <= 4'd2) ? YW'(1) : YW'(0));
    doya   = doy_of(in_month_a) + DOY_BITS'(in_day_a) - DOY_BITS'(1);
    doyb   = doy_of(in_month_b) + DOY_BITS'(in_day_b) - DOY_BITS'(1);
  end

  // Leap flags of the current year and the next one.
  always_comb begin
    y_inc    = y_r + YW'(1);
    cyc_inc  = (cyc_r == CYC_BITS'(YEAR_CYCLE - 1)) ? '0 : cyc_r + CYC_BITS'(1);
    leap_cur = leap_f(y_r[1:0], cyc_r);
    leap_nxt = leap_f(y_inc[1:0], cyc_inc);
    ylen     = DOY_BITS'(YEAR_DAYS) + DOY_BITS'(leap_nxt);
    mlen     = mar_len(mp_r, leap_nxt);
  end

  // Date validation with the leap flags caught during the walk.
  always_comb begin
    valid_a = (ma_r >= 4'd1) && (ma_r <= MONTH_BITS'(MONTHS)) && (da_r != '0) &&
              (da_r <= civil_len(ma_r, leap_a_r));
    valid_b = (mb_r >= 4'd1) && (mb_r <= MONTH_BITS'(MONTHS)) && (db_r != '0) &&
              (db_r <= civil_len(mb_r, leap_b_r));
    invalid = !valid_a || ((cmd_r == CMD_DIFF) && !valid_b);
  end

  // Absolute difference, saturated to the output width.
  always_comb begin
    sum_hi   = MW'(acc_r) + MW'(doy_hi_r);
    lo_ext   = MW'(doy_lo_r);
    mag      = (sum_hi >= lo_ext) ? sum_hi - lo_ext : lo_ext - sum_hi;
    diff_sat = (mag > MW'(DIFF_MAX)) ? DIFF_BITS'(DIFF_MAX) : DIFF_BITS'(mag);
  end

  // Final month and year of an add.
  always_comb begin
    res_month = (mp_r < MONTH_BITS'(MAR_SPLIT)) ? mp_r + 4'd3 : mp_r - 4'd9;
    res_year  = y_r + ((res_month <= 4'd2) ? YW'(1) : YW'(0));
  end

  // Status to the controller.
  always_comb begin
    dp_sts.walk_done = (y_r == target_r);
    dp_sts.invalid   = invalid;
    dp_sts.is_add    = (cmd_r == CMD_ADD);
    dp_sts.era_ge    = (n_r >= NW'(ERA_DAYS));
    dp_sts.year_ge   = (n_r >= NW'(ylen));
    dp_sts.month_ge  = (n_r >= NW'(mlen));
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r    <= in_cmd;
      ma_r     <= in_month_a;
      da_r     <= in_day_a;
      mb_r     <= in_month_b;
      db_r     <= in_day_b;
      ya_r     <= ya_ext;
      yb_r     <= yb_ext;
      cnt_r    <= in_day_count;
      doya_r   <= doya;
      lo_r     <= (yya <= yyb) ? yya : yyb;
      hi_r     <= (yya <= yyb) ? yyb : yya;
      doy_lo_r <= (yya <= yyb) ? doya : doyb;
      doy_hi_r <= (yya <= yyb) ? doyb : doya;
      target_r <= (in_cmd == CMD_ADD) ? yya : ((yya <= yyb) ? yyb : yya);
    end
  end

  // Year walk from the bottom of the range, then era, year and month steps.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      y_r   <= YW'(BaseYear);
      cyc_r <= CYC_BITS'(BaseCyc);
      acc_r <= '0;
    end else if (dp_cmd.walk) begin
      if (y_r == ya_r) begin
        leap_a_r <= leap_cur;
      end else if (y_inc == ya_r) begin
        leap_a_r <= leap_nxt;
      end
      if (y_r == yb_r) begin
        leap_b_r <= leap_cur;
      end else if (y_inc == yb_r) begin
        leap_b_r <= leap_nxt;
      end
      if ((cmd_r == CMD_DIFF) && (y_r >= lo_r) && (y_r < hi_r)) begin
        acc_r <= acc_r + AW'(ylen);
      end
      if (y_r != target_r) begin
        y_r   <= y_inc;
        cyc_r <= cyc_inc;
      end
    end else if (dp_cmd.check) begin
      n_r  <= NW'(doya_r) + NW'(cnt_r);
      mp_r <= '0;
    end else if (dp_cmd.era) begin
      // A 400-year block leaves the year modulo 400 unchanged.
      if (dp_sts.era_ge) begin
        n_r <= n_r - NW'(ERA_DAYS);
        y_r <= y_r + YW'(YEAR_CYCLE);
      end
    end else if (dp_cmd.year) begin
      if (dp_sts.year_ge) begin
        n_r   <= n_r - NW'(ylen);
        y_r   <= y_inc;
        cyc_r <= cyc_inc;
      end
    end else if (dp_cmd.month) begin
      if (dp_sts.month_ge) begin
        n_r  <= n_r - NW'(mlen);
        mp_r <= mp_r + 4'd1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.check && (invalid || (cmd_r == CMD_DIFF))) begin
      out_day_difference <= invalid ? '0 : diff_sat;
      out_result_month   <= '0;
      out_result_day     <= '0;
      out_result_year    <= '0;
      out_date_invalid   <= invalid;
      out_year_overflow  <= 1'b0;
    end else if (dp_cmd.month && !dp_sts.month_ge) begin
      out_day_difference <= '0;
      out_result_month   <= res_month;
      out_result_day     <= DAY_BITS'(n_r) + 5'd1;
      out_result_year    <= res_year[YEAR_BITS-1:0];
      out_date_invalid   <= 1'b0;
      out_year_overflow  <= (res_year > YW'(MaxYear));
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/gregorian_date_add_and_difference_unit_tb.sv =====
`timescale 1ns / 100ps

module gregorian_date_add_and_difference_unit_tb;

  import gdad_pkg::*;

  localparam int YEAR_BITS = 13;
  // Offset that makes every year positive for the calendar arithmetic.
  localparam longint YEAR_OFFSET = 800000;
  localparam longint LATEST_YEAR = (longint'(1) << (YEAR_BITS - 1)) - 1;
  localparam int MAX_COUNT = 4194303;
  // Time limit for the whole run, in nanoseconds.
  localparam longint RUN_LIMIT_NS = 80_000_000;

  typedef struct {
    logic                        cmd;
    logic [MONTH_BITS-1:0]       month_a;
    logic [DAY_BITS-1:0]         day_a;
    logic signed [YEAR_BITS-1:0] year_a;
    logic [MONTH_BITS-1:0]       month_b;
    logic [DAY_BITS-1:0]         day_b;
    logic signed [YEAR_BITS-1:0] year_b;
    logic [COUNT_BITS-1:0]       day_count;
  } date_request_t;

  typedef struct {
    logic [DIFF_BITS-1:0]        day_difference;
    logic [MONTH_BITS-1:0]       month;
    logic [DAY_BITS-1:0]         day;
    logic signed [YEAR_BITS-1:0] year;
    logic                        invalid;
    logic                        overflow;
  } date_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_cmd;
  logic [3:0]                  in_month_a;
  logic [4:0]                  in_day_a;
  logic signed [YEAR_BITS-1:0] in_year_a;
  logic [3:0]                  in_month_b;
  logic [4:0]                  in_day_b;
  logic signed [YEAR_BITS-1:0] in_year_b;
  logic [21:0]                 in_day_count;
  logic                        out_valid;
  logic [21:0]                 out_day_difference;
  logic [3:0]                  out_result_month;
  logic [4:0]                  out_result_day;
  logic signed [YEAR_BITS-1:0] out_result_year;
  logic                        out_date_invalid;
  logic                        out_year_overflow;

  date_result_t results_due[$];
  int           mismatch_count = 0;
  bit           gaps_on = 1'b0;

  gregorian_date_add_and_difference_unit #(
    .YEAR_BITS(YEAR_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_month_a        (in_month_a),
    .in_day_a          (in_day_a),
    .in_year_a         (in_year_a),
    .in_month_b        (in_month_b),
    .in_day_b          (in_day_b),
    .in_year_b         (in_year_b),
    .in_day_count      (in_day_count),
    .out_valid         (out_valid),
    .out_day_difference(out_day_difference),
    .out_result_month  (out_result_month),
    .out_result_day    (out_result_day),
    .out_result_year   (out_result_year),
    .out_date_invalid  (out_date_invalid),
    .out_year_overflow (out_year_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Calendar arithmetic on offset (always positive) years.
  function automatic bit is_leap(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint offset_year(input logic signed [YEAR_BITS-1:0] y);
    return longint'(y) + YEAR_OFFSET;
  endfunction

  function automatic longint days_in_month(input logic [MONTH_BITS-1:0] m, input longint y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
      4'd2:                                       return is_leap(y) ? 29 : 28;
      default:                                    return 0;
    endcase
  endfunction

  function automatic bit date_valid(input logic [MONTH_BITS-1:0] m,
                                    input logic [DAY_BITS-1:0] d, input longint y);
    return (m >= 1) && (m <= 12) && (d >= 1) && (longint'(d) <= days_in_month(m, y));
  endfunction

  // Serial day number with the year starting on March 1.
  function automatic longint serial_day(input logic [MONTH_BITS-1:0] m,
                                        input logic [DAY_BITS-1:0] d, input longint y);
    longint yy, era, yoe, mp, doy;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (longint'(m) + 9) % 12;
    doy = (153 * mp + 2) / 5 + longint'(d) - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  function automatic void serial_to_date(input longint z, output longint m,
                                         output longint d, output longint y);
    longint era, doe, yoe, doy, mp;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // Expected result of one request.
  function automatic date_result_t predict_date_result(input date_request_t r);
    date_result_t res;
    longint ya, yb, na, nb, diff, rm, rd, ry, true_year;
    res = '{default: '0};
    ya = offset_year(r.year_a);
    yb = offset_year(r.year_b);
    if (r.cmd == CMD_DIFF) begin
      if (!date_valid(r.month_a, r.day_a, ya) || !date_valid(r.month_b, r.day_b, yb)) begin
        res.invalid = 1'b1;
      end else begin
        na = serial_day(r.month_a, r.day_a, ya);
        nb = serial_day(r.month_b, r.day_b, yb);
        diff = (na > nb) ? na - nb : nb - na;
        res.day_difference = (diff > DIFF_MAX) ? DIFF_BITS'(DIFF_MAX) : DIFF_BITS'(diff);
      end
    end else begin
      if (!date_valid(r.month_a, r.day_a, ya)) begin
        res.invalid = 1'b1;
      end else begin
        serial_to_date(serial_day(r.month_a, r.day_a, ya) + longint'(r.day_count), rm, rd, ry);
        true_year    = ry - YEAR_OFFSET;
        res.month    = MONTH_BITS'(rm);
        res.day      = DAY_BITS'(rd);
        res.year     = YEAR_BITS'(true_year);
        res.overflow = (true_year > LATEST_YEAR);
      end
    end
    return res;
  endfunction

  function automatic date_request_t make_request(
      input logic cmd, input int ma, input int da, input int ya,
      input int mb, input int db, input int yb, input int cnt);
    date_request_t r;
    r.cmd       = cmd;
    r.month_a   = MONTH_BITS'(ma);
    r.day_a     = DAY_BITS'(da);
    r.year_a    = YEAR_BITS'(ya);
    r.month_b   = MONTH_BITS'(mb);
    r.day_b     = DAY_BITS'(db);
    r.year_b    = YEAR_BITS'(yb);
    r.day_count = COUNT_BITS'(cnt);
    return r;
  endfunction

  function automatic logic signed [YEAR_BITS-1:0] random_year();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(YEAR_BITS-1){1'b0}}};
      1:       return {1'b0, {(YEAR_BITS-1){1'b1}}};
      default: return YEAR_BITS'($urandom);
    endcase
  endfunction

  // Well-formed requests carry valid dates; the rest have arbitrary field bits.
  function automatic date_request_t random_request(input bit well_formed);
    date_request_t r;
    r.cmd    = 1'($urandom);
    r.year_a = random_year();
    r.year_b = random_year();
    if (well_formed) begin
      r.month_a = MONTH_BITS'($urandom_range(1, 12));
      r.day_a   = DAY_BITS'($urandom_range(1,
                    int'(days_in_month(r.month_a, offset_year(r.year_a)))));
      r.month_b = MONTH_BITS'($urandom_range(1, 12));
      r.day_b   = DAY_BITS'($urandom_range(1,
                    int'(days_in_month(r.month_b, offset_year(r.year_b)))));
    end else begin
      r.month_a = MONTH_BITS'($urandom);
      r.day_a   = DAY_BITS'($urandom);
      r.month_b = MONTH_BITS'($urandom);
      r.day_b   = DAY_BITS'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       r.day_count = COUNT_BITS'($urandom_range(0, 400));
      1:       r.day_count = COUNT_BITS'($urandom_range(0, 40000));
      default: r.day_count = COUNT_BITS'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Present one request and wait until the block takes it.
  task automatic send_request(input date_request_t r);
    @(negedge clk);
    start        <= 1'b1;
    in_cmd       <= r.cmd;
    in_month_a   <= r.month_a;
    in_day_a     <= r.day_a;
    in_year_a    <= r.year_a;
    in_month_b   <= r.month_b;
    in_day_b     <= r.day_b;
    in_year_b    <= r.year_b;
    in_day_count <= r.day_count;
    @(posedge clk);
    while (busy) @(posedge clk);
    results_due.push_back(predict_date_result(r));
  endtask

  // Random idle burst on the request side, counted once the block is free.
  task automatic idle_burst();
    int n;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk) start <= 1'b0;
      while (busy) @(negedge clk);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk) start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Compare each result strobe against the oldest outstanding request.
  always @(posedge clk) begin : result_check
    date_result_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = results_due.pop_front();
        if (out_day_difference !== want.day_difference)
          report_mismatch($sformatf("day_difference got %0d expected %0d",
                                    out_day_difference, want.day_difference));
        if (out_result_month !== want.month)
          report_mismatch($sformatf("result_month got %0d expected %0d",
                                    out_result_month, want.month));
        if (out_result_day !== want.day)
          report_mismatch($sformatf("result_day got %0d expected %0d",
                                    out_result_day, want.day));
        if (out_result_year !== want.year)
          report_mismatch($sformatf("result_year got %0d expected %0d",
                                    out_result_year, want.year));
        if (out_date_invalid !== want.invalid)
          report_mismatch($sformatf("date_invalid got %b expected %b",
                                    out_date_invalid, want.invalid));
        if (out_year_overflow !== want.overflow)
          report_mismatch($sformatf("year_overflow got %b expected %b",
                                    out_year_overflow, want.overflow));
      end
    end
  end

  // Field extremes, leap rules, invalid dates and year wrap on add.
  task automatic test_directed_cases();
    date_request_t list[$];
    list.push_back(make_request(CMD_DIFF, 3, 15, 2024, 3, 15, 2024, 0));
    list.push_back(make_request(CMD_DIFF, 1, 1, -4096, 12, 31, 4095, 0));
    list.push_back(make_request(CMD_DIFF, 12, 31, 4095, 1, 1, -4096, MAX_COUNT));
    list.push_back(make_request(CMD_DIFF, 2, 29, 2000, 3, 1, 1900, 0));
    list.push_back(make_request(CMD_DIFF, 2, 29, 1900, 1, 1, 1900, 0));
    list.push_back(make_request(CMD_DIFF, 2, 29, 0, 1, 1, 1, 0));
    list.push_back(make_request(CMD_DIFF, 2, 29, -100, 1, 1, 0, 0));
    list.push_back(make_request(CMD_DIFF, 1, 1, 0, 2, 29, -400, 0));
    list.push_back(make_request(CMD_DIFF, 0, 10, 10, 5, 5, 5, 0));
    list.push_back(make_request(CMD_DIFF, 5, 5, 5, 13, 10, 10, 0));
    list.push_back(make_request(CMD_DIFF, 15, 31, -1, 1, 1, 1, 0));
    list.push_back(make_request(CMD_DIFF, 7, 4, 1776, 7, 0, 1776, 0));
    list.push_back(make_request(CMD_DIFF, 4, 31, 2021, 5, 1, 2021, 0));
    list.push_back(make_request(CMD_DIFF, 1, 31, -1, 12, 31, 1, 0));
    list.push_back(make_request(CMD_ADD, 6, 30, -1, 0, 0, 0, 0));
    list.push_back(make_request(CMD_ADD, 2, 28, 2023, 0, 0, 0, 1));
    list.push_back(make_request(CMD_ADD, 2, 28, 2024, 0, 0, 0, 1));
    list.push_back(make_request(CMD_ADD, 12, 31, -1, 0, 0, 0, 1));
    list.push_back(make_request(CMD_ADD, 12, 31, 4095, 0, 0, 0, 1));
    list.push_back(make_request(CMD_ADD, 12, 31, 4095, 0, 0, 0, MAX_COUNT));
    list.push_back(make_request(CMD_ADD, 1, 1, -4096, 0, 0, 0, MAX_COUNT));
    list.push_back(make_request(CMD_ADD, 2, 30, 2020, 1, 1, 1, 10));
    list.push_back(make_request(CMD_ADD, 3, 1, 1, 15, 0, -4096, 365));
    list.push_back(make_request(CMD_ADD, 0, 0, 100, 1, 1, 1, 5));
    list.push_back(make_request(CMD_ADD, 4, 30, -4096, 2, 2, 2, 0));
    foreach (list[i]) begin
      send_request(list[i]);
      idle_burst();
    end
  endtask

  // Mostly valid dates with random content, the rest arbitrary field bits.
  task automatic test_random_traffic(input int n);
    repeat (n) begin
      send_request(random_request($urandom_range(0, 99) < 85));
      idle_burst();
    end
  endtask

  // Let the block go fully idle, then start again from an empty pipeline.
  task automatic test_drain_then_resume();
    wait_for_results();
    test_random_traffic(10);
  endtask

  // Requests held ready the whole time, with no idle cycles.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_traffic(30);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = 1'b0;
    in_month_a   = '0;
    in_day_a     = '0;
    in_year_a    = '0;
    in_month_b   = '0;
    in_day_b     = '0;
    in_year_b    = '0;
    in_day_count = '0;
    repeat (9) @(negedge clk);
    rst_n   <= 1'b1;
    gaps_on = 1'b1;

    test_directed_cases();
    test_random_traffic(35);
    test_drain_then_resume();
    test_back_to_back();

    wait_for_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gregorian_date_add_and_difference_unit verification clean");
    end else begin
      $display("gregorian_date_add_and_difference_unit verification failed");
    end
    $finish;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("gregorian_date_add_and_difference_unit verification failed");
    $finish;
  end

endmodule
